[sv/ise_pkg.sv]
// Shared types and constants for the indexed sequence editor.
package ise_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int POS_W        = 10;
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 11;
    localparam int FUNC_W       = 2;
    localparam int STAT_W       = 2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    read_present;
        logic [LEN_W-1:0]        length;
        logic [STAT_W-1:0]       status;
    } t_out_item;

endpackage

[sv/ise_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
module ise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/indexed_sequence_editor_core.sv]
// Top level of the indexed sequence editor: sequencer around one sequence RAM.
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in one RAM and
// applies one edit per input beat (append, insert before position, delete at
// position, replace at position), then returns one result beat with the new
// length, a status code and the value at the configured read position. Edits are
// handled one at a time. An append or replace writes the RAM (S_PUT), reads the
// read position (S_READ) and loads the result (S_RESP); a rejected edit or a
// delete of the last entry skips S_PUT. An insert moves entries up (S_SHIFT)
// before S_PUT, a delete moves them down (S_SHIFT) before S_READ: the RAM does
// one read and one write per cycle, so the entry move runs one entry a cycle,
// up to CAPACITY - 1 entries. The next edit is taken in the cycle after its
// result is loaded. A finished result waits in an output register; the next edit
// is accepted while it waits, and a further result holds the sequencer until the
// register frees. No clearing pass follows reset.
module indexed_sequence_editor_core #(
    parameter int CAPACITY = ise_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ise_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ise_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_we,
    input  logic [ise_pkg::POS_W-1:0]    i_cfg_wdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > ise_pkg::POS_W) ? CW : ise_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_READ,
        S_RESP
    } t_state;

    t_state                            r_state;
    logic [CW-1:0]                     r_count;
    logic [ise_pkg::POS_W-1:0]         r_rdpos;
    logic [AW-1:0]                     r_idx;
    logic [AW-1:0]                     r_end;
    logic [AW-1:0]                     r_wa;
    logic [AW-1:0]                     r_put;
    logic                              r_more;
    logic                              r_pend;
    logic                              r_ins;
    logic signed [ise_pkg::VAL_W-1:0]  r_val;
    logic [ise_pkg::STAT_W-1:0]        r_status;
    logic                              r_present;
    logic                              r_out_valid;
    ise_pkg::t_out_item                r_out;

    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [ise_pkg::VAL_W-1:0]         ram_wdata;
    logic                              ram_re;
    logic [AW-1:0]                     ram_raddr;
    logic [ise_pkg::VAL_W-1:0]         ram_rdata;

    logic [CMPW-1:0]                   pos_x;
    logic [CMPW-1:0]                   cnt_x;
    logic [CMPW-1:0]                   rdpos_x;
    logic                              full;
    logic                              out_free;

    ise_ram #(
        .WIDTH (ise_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Compare positions against the length in a common width
    assign pos_x    = CMPW'(i_in_data.position);
    assign cnt_x    = CMPW'(r_count);
    assign rdpos_x  = CMPW'(r_rdpos);
    assign full     = (r_count == CW'(CAPACITY));
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Drive the RAM ports from the sequencer state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        case (r_state)
            S_SHIFT: begin
                ram_we = r_pend;
                ram_re = r_more;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_put;
                ram_wdata = r_val;
            end
            S_READ: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_rdpos);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer, length, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rdpos     <= '0;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rdpos <= i_cfg_wdata;
            end

            // Drop the result once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_val  <= i_in_data.value;
                        r_ins  <= (i_in_data.func == ise_pkg::FUNC_INSERT);
                        r_more <= 1'b1;
                        r_pend <= 1'b0;
                        case (i_in_data.func)
                            ise_pkg::FUNC_APPEND: begin
                                if (full) begin
                                    r_status <= ise_pkg::STAT_FULL;
                                    r_state  <= S_READ;
                                end else begin
                                    r_status <= ise_pkg::STAT_DONE;
                                    r_put    <= AW'(r_count);
                                    r_count  <= r_count + CW'(1);
                                    r_state  <= S_PUT;
                                end
                            end
                            ise_pkg::FUNC_INSERT: begin
                                if (pos_x > cnt_x) begin
                                    r_status <= ise_pkg::STAT_RANGE;
                                    r_state  <= S_READ;
                                end else if (full) begin
                                    r_status <= ise_pkg::STAT_FULL;
                                    r_state  <= S_READ;
                                end else begin
                                    r_status <= ise_pkg::STAT_DONE;
                                    r_put    <= AW'(i_in_data.position);
                                    r_count  <= r_count + CW'(1);
                                    if (pos_x < cnt_x) begin
                                        r_idx   <= AW'(cnt_x - CMPW'(1));
                                        r_end   <= AW'(i_in_data.position);
                                        r_state <= S_SHIFT;
                                    end else begin
                                        r_state <= S_PUT;
                                    end
                                end
                            end
                            ise_pkg::FUNC_DELETE: begin
                                if (pos_x >= cnt_x) begin
                                    r_status <= ise_pkg::STAT_RANGE;
                                    r_state  <= S_READ;
                                end else begin
                                    r_status <= ise_pkg::STAT_DONE;
                                    r_count  <= r_count - CW'(1);
                                    if ((pos_x + CMPW'(1)) < cnt_x) begin
                                        r_idx   <= AW'(pos_x + CMPW'(1));
                                        r_end   <= AW'(cnt_x - CMPW'(1));
                                        r_state <= S_SHIFT;
                                    end else begin
                                        r_state <= S_READ;
                                    end
                                end
                            end
                            default: begin
                                if (pos_x >= cnt_x) begin
                                    r_status <= ise_pkg::STAT_RANGE;
                                    r_state  <= S_READ;
                                end else begin
                                    r_status <= ise_pkg::STAT_DONE;
                                    r_put    <= AW'(i_in_data.position);
                                    r_state  <= S_PUT;
                                end
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    // Read one entry ahead, write the previous one a slot over
                    r_pend <= r_more;
                    if (r_more) begin
                        r_wa <= r_ins ? (r_idx + AW'(1)) : (r_idx - AW'(1));
                        if (r_idx == r_end) begin
                            r_more <= 1'b0;
                        end else begin
                            r_idx <= r_ins ? (r_idx - AW'(1)) : (r_idx + AW'(1));
                        end
                    end
                    if (!r_more && !r_pend) begin
                        r_state <= r_ins ? S_PUT : S_READ;
                    end
                end
                S_PUT: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_present <= (rdpos_x < cnt_x);
                    r_state   <= S_RESP;
                end
                S_RESP: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_out.read_value   <= r_present ? $signed(ram_rdata) : '0;
                        r_out.read_present <= r_present;
                        r_out.length       <= ise_pkg::LEN_W'(r_count);
                        r_out.status       <= r_status;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
